[rtl/core/ctpt_pkg.sv]
// Shared types and constants for the counter priority task picker.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`default_nettype none

package ctpt_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_NUM_SLOTS  = 64;
   localparam int DEF_COUNT_BITS = 8;

   // Depth of the command queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;

   // Fixed field widths of the request and response channels.
   localparam int KIND_BITS     = 2;
   localparam int SLOT_BITS     = 6;
   localparam int VALUE_BITS    = 8;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 16;

   // Request kind codes as they appear on the bus.
   localparam logic [KIND_BITS-1:0] KIND_WRITE_ENTRY  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SET_RUNNABLE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_SCHEDULE     = 2'd2;
   // This kind carries no operation; it is taken and dropped.
   localparam logic [KIND_BITS-1:0] KIND_UNUSED       = 2'd3;

   // Operation carried through the queue once a request is classified.
   typedef enum logic [1:0] {
      OP_WRITE_ENTRY,
      OP_SET_RUNNABLE,
      OP_SCHEDULE
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [SLOT_BITS-1:0]   slot;
      logic                   present;
      logic                   runnable;
      logic [VALUE_BITS-1:0]  priority_val;
      logic [VALUE_BITS-1:0]  count_val;
   } task_cmd_type;

endpackage

`default_nettype wire

[rtl/core/counter_priority_task_picker.sv]
// Top level of the counter priority task picker: front end, command queue
// and back end. Depends on ctpt_pkg, ctpt_front, ctpt_queue and ctpt_back.
`default_nettype none

// The picker keeps a table of NUM_SLOTS task slots, each with a present mark,
// a runnable mark, a priority and a remaining count. A request of kind 0
// writes a whole slot entry, kind 1 sets only the runnable mark, and kind 2
// asks for a pick; kind 3 and writes to slots beyond the table are taken and
// ignored. A pick scans the slots from the top down to slot 1 and chooses the
// runnable present slot with the largest count, the higher slot winning a
// tie. When that largest count is zero, every present slot's count is loaded
// from its priority and the table is scanned once more; if the counts are
// still zero the highest runnable slot is chosen and starved is set. With no
// runnable slot the idle task, slot 0, is chosen. Only picks give a response.
// Requests go through a two-entry queue, so up to two requests are taken
// while the back end scans or a response waits; once both entries are held,
// req_tready stays low until the back end takes the oldest one. A write is
// carried out as the back end takes it from the queue. A pick makes one pass
// over the slots, or two when it reloads: the back end reads one slot per
// cycle through the single read port of the count and priority memories,
// and the reload is folded into the second pass as it writes each present
// slot's count back through the count memory's write port. Nothing needs to
// be cleared after reset; the table is usable as soon as reset is released.
module counter_priority_task_picker #(
   parameter int NUM_SLOTS  = ctpt_pkg::DEF_NUM_SLOTS,
   parameter int COUNT_BITS = ctpt_pkg::DEF_COUNT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // From bit 0: slot[5:0], present[6], runnable[7], priority_req[15:8],
   // count[23:16].
   input  wire logic [ctpt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // From bit 0: kind[1:0].
   input  wire logic [ctpt_pkg::KIND_BITS-1:0]     req_tuser,
   // Response channel.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // From bit 0: chosen_slot[5:0], switch_task[6], idle[7], reloaded[8],
   // starved[9], zero fill[15:10].
   output logic [ctpt_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);

   ctpt_pkg::task_cmd_type push_cmd;
   ctpt_pkg::task_cmd_type head_cmd;
   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_not_empty;

   // The front end classifies each request and queues the ones that act.
   ctpt_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   ctpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .head_cmd  (head_cmd),
      .not_empty (q_not_empty)
   );

   // The back end owns the slot table and the response register.
   ctpt_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

[rtl/core/ctpt_front.sv]
// Front end of the task picker: takes requests, decodes the kind and drops
// requests that change nothing. Depends on ctpt_pkg.
`default_nettype none

module ctpt_front #(
   parameter int NUM_SLOTS = ctpt_pkg::DEF_NUM_SLOTS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ctpt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [ctpt_pkg::KIND_BITS-1:0]     req_tuser,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output ctpt_pkg::task_cmd_type                 q_cmd
);

   logic keep;
   logic in_range;

   assign req_tready = !q_full;

   assign in_range = 32'(req_tdata[5:0]) < NUM_SLOTS;

   always_comb begin
      q_cmd.slot         = req_tdata[5:0];
      q_cmd.present      = req_tdata[6];
      q_cmd.runnable     = req_tdata[7];
      q_cmd.priority_val = req_tdata[15:8];
      q_cmd.count_val    = req_tdata[23:16];
      unique case (req_tuser)
         ctpt_pkg::KIND_WRITE_ENTRY: begin
            q_cmd.op = ctpt_pkg::OP_WRITE_ENTRY;
            keep     = in_range;
         end
         ctpt_pkg::KIND_SET_RUNNABLE: begin
            q_cmd.op = ctpt_pkg::OP_SET_RUNNABLE;
            keep     = in_range;
         end
         ctpt_pkg::KIND_SCHEDULE: begin
            q_cmd.op = ctpt_pkg::OP_SCHEDULE;
            keep     = 1'b1;
         end
         default: begin
            // The unused kind is taken and discarded.
            q_cmd.op = ctpt_pkg::OP_SCHEDULE;
            keep     = 1'b0;
         end
      endcase
   end

   assign q_push = req_tvalid && req_tready && keep;

   // No request may be pushed into the queue while it is full.
   property p_no_push_when_full;
      @(posedge clock) disable iff (reset) q_full |-> !q_push;
   endproperty
   a_no_push_when_full: assert property (p_no_push_when_full)
      else $error("push into a full command queue");

   property p_unused_kind_dropped;
      @(posedge clock) disable iff (reset) (req_tuser == ctpt_pkg::KIND_UNUSED) |-> !q_push;
   endproperty
   a_unused_kind_dropped: assert property (p_unused_kind_dropped)
      else $error("unused request kind reached the queue");

   property p_range_dropped;
      @(posedge clock) disable iff (reset)
         (q_push && q_cmd.op != ctpt_pkg::OP_SCHEDULE) |-> in_range;
   endproperty
   a_range_dropped: assert property (p_range_dropped)
      else $error("write to a slot beyond the table was queued");

endmodule

`default_nettype wire

[rtl/core/ctpt_queue.sv]
// Short command queue between the front end and the back end of the task
// picker. Depends on ctpt_pkg.
`default_nettype none

module ctpt_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  ctpt_pkg::task_cmd_type     push_cmd,
   output logic                       full,
   input  wire logic                  pop,
   output ctpt_pkg::task_cmd_type     head_cmd,
   output logic                       not_empty
);

   localparam int DEPTH  = ctpt_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   ctpt_pkg::task_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;

   assign full      = fill_ff == FILL_W'(DEPTH);
   assign not_empty = fill_ff != '0;
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   property p_no_underflow;
      @(posedge clock) disable iff (reset) pop |-> not_empty;
   endproperty
   a_no_underflow: assert property (p_no_underflow)
      else $error("pop from an empty command queue");

   property p_no_overflow;
      @(posedge clock) disable iff (reset) (push && !pop) |-> !full;
   endproperty
   a_no_overflow: assert property (p_no_overflow)
      else $error("push into a full command queue");

   property p_fill_bound;
      @(posedge clock) disable iff (reset) fill_ff <= FILL_W'(DEPTH);
   endproperty
   a_fill_bound: assert property (p_fill_bound)
      else $error("command queue fill count beyond its depth");

endmodule

`default_nettype wire

[rtl/core/ctpt_back.sv]
// Back end of the task picker: holds the slot table, carries out writes and
// runs the scan and the reload-and-rescan. Drives the response register.
// Depends on ctpt_pkg.
`default_nettype none

module ctpt_back #(
   parameter int NUM_SLOTS  = ctpt_pkg::DEF_NUM_SLOTS,
   parameter int COUNT_BITS = ctpt_pkg::DEF_COUNT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_not_empty,
   input  ctpt_pkg::task_cmd_type                  q_cmd,
   output logic                                    q_pop,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [ctpt_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESCAN,
      ST_DONE
   } state_type;

   state_type state_ff;

   // Slot table: marks in flip-flops, priority and count in memories.
   logic [NUM_SLOTS-1:0]  present_ff;
   logic [NUM_SLOTS-1:0]  runnable_ff;
   logic [COUNT_BITS-1:0] count_mem    [NUM_SLOTS];
   logic [COUNT_BITS-1:0] priority_mem [NUM_SLOTS];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [COUNT_BITS-1:0] pri_rd_ff;

   // Scan pipeline: read address stage and compare stage.
   logic [SLOT_W-1:0]     iss_ff;
   logic                  iss_vld_ff;
   logic [SLOT_W-1:0]     cmp_slot_ff;
   logic                  cmp_vld_ff;

   // Running best of the current pass.
   logic                  found_ff;
   logic [COUNT_BITS-1:0] best_ff;
   logic [SLOT_W-1:0]     pick_ff;
   logic                  reloaded_ff;
   logic [SLOT_W-1:0]     current_ff;

   logic                  found_in;
   logic [COUNT_BITS-1:0] best_in;
   logic [SLOT_W-1:0]     pick_in;

   logic                  rsp_valid_ff;
   logic [ctpt_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                  res_starved_ff;

   logic [SLOT_W-1:0]     q_idx;
   logic                  take_write;
   logic                  cnt_we;
   logic [SLOT_W-1:0]     cnt_wa;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic [COUNT_BITS-1:0] cmp_val;
   logic                  candidate;
   logic                  pass_end;
   logic                  rsp_free;

   assign q_idx      = SLOT_W'(q_cmd.slot);
   assign q_pop      = (state_ff == ST_IDLE) && q_not_empty;
   assign take_write = q_pop && (q_cmd.op == ctpt_pkg::OP_WRITE_ENTRY);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // In the rescan the freshly reloaded value is the priority itself.
   assign cmp_val   = (state_ff == ST_RESCAN) ? pri_rd_ff : cnt_rd_ff;
   assign candidate = cmp_vld_ff && present_ff[cmp_slot_ff] && runnable_ff[cmp_slot_ff];
   assign pass_end  = cmp_vld_ff && (cmp_slot_ff == LAST_SLOT);

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      pick_in  = pick_ff;
      // Strictly greater: the higher slot, seen first, keeps a tie.
      if (candidate && (!found_ff || cmp_val > best_ff)) begin
         found_in = 1'b1;
         best_in  = cmp_val;
         pick_in  = cmp_slot_ff;
      end
   end

   // Count memory write port: entry writes when idle, reloads in the rescan.
   always_comb begin
      if (state_ff == ST_RESCAN) begin
         cnt_we = cmp_vld_ff && present_ff[cmp_slot_ff];
         cnt_wa = cmp_slot_ff;
         cnt_wd = pri_rd_ff;
      end else begin
         cnt_we = take_write;
         cnt_wa = q_idx;
         cnt_wd = COUNT_BITS'(q_cmd.count_val);
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= count_mem[iss_ff];
   end

   always_ff @(posedge clock) begin
      if (take_write) begin
         priority_mem[q_idx] <= COUNT_BITS'(q_cmd.priority_val);
      end
      pri_rd_ff <= priority_mem[iss_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         runnable_ff <= '0;
      end else if (q_pop && q_cmd.op != ctpt_pkg::OP_SCHEDULE) begin
         runnable_ff[q_idx] <= q_cmd.runnable;
         if (q_cmd.op == ctpt_pkg::OP_WRITE_ENTRY) begin
            present_ff[q_idx] <= q_cmd.present;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         iss_ff         <= '0;
         iss_vld_ff     <= 1'b0;
         cmp_slot_ff    <= '0;
         cmp_vld_ff     <= 1'b0;
         found_ff       <= 1'b0;
         best_ff        <= '0;
         pick_ff        <= '0;
         reloaded_ff    <= 1'b0;
         res_starved_ff <= 1'b0;
         current_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_data_ff    <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         cmp_slot_ff <= iss_ff;
         cmp_vld_ff  <= iss_vld_ff;
         if (iss_vld_ff) begin
            if (iss_ff == LAST_SLOT) begin
               iss_vld_ff <= 1'b0;
            end else begin
               iss_ff <= iss_ff - 1'b1;
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop && q_cmd.op == ctpt_pkg::OP_SCHEDULE) begin
                  state_ff       <= ST_SCAN;
                  iss_ff         <= TOP_SLOT;
                  iss_vld_ff     <= 1'b1;
                  found_ff       <= 1'b0;
                  best_ff        <= '0;
                  pick_ff        <= '0;
                  reloaded_ff    <= 1'b0;
                  res_starved_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               found_ff <= found_in;
               best_ff  <= best_in;
               pick_ff  <= pick_in;
               if (pass_end) begin
                  if (found_in && best_in == '0) begin
                     state_ff    <= ST_RESCAN;
                     iss_ff      <= TOP_SLOT;
                     iss_vld_ff  <= 1'b1;
                     found_ff    <= 1'b0;
                     best_ff     <= '0;
                     pick_ff     <= '0;
                     reloaded_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_RESCAN: begin
               found_ff <= found_in;
               best_ff  <= best_in;
               pick_ff  <= pick_in;
               if (pass_end) begin
                  state_ff       <= ST_DONE;
                  res_starved_ff <= found_in && best_in == '0;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  state_ff     <= ST_IDLE;
                  current_ff   <= pick_ff;
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {6'd0, res_starved_ff, reloaded_ff, !found_ff,
                                   pick_ff != current_ff,
                                   ctpt_pkg::SLOT_BITS'(pick_ff)};
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   property p_reload_flag_in_rescan;
      @(posedge clock) disable iff (reset) (state_ff == ST_RESCAN) |-> reloaded_ff;
   endproperty
   a_reload_flag_in_rescan: assert property (p_reload_flag_in_rescan)
      else $error("rescan running without the reload flag");

   property p_pop_only_idle;
      @(posedge clock) disable iff (reset) q_pop |-> (state_ff == ST_IDLE);
   endproperty
   a_pop_only_idle: assert property (p_pop_only_idle)
      else $error("command taken while a pick is in progress");

   property p_starved_needs_reload;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> (!rsp_data_ff[9] || (rsp_data_ff[8] && !rsp_data_ff[7]));
   endproperty
   a_starved_needs_reload: assert property (p_starved_needs_reload)
      else $error("starvation reported without a reload or while idle");

   property p_idle_picks_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_data_ff[7]) |-> (rsp_data_ff[5:0] == 6'd0);
   endproperty
   a_idle_picks_zero: assert property (p_idle_picks_zero)
      else $error("idle pick names a slot other than zero");

   property p_result_updates_current;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_DONE && rsp_free) |=> (current_ff == $past(pick_ff));
   endproperty
   a_result_updates_current: assert property (p_result_updates_current)
      else $error("current slot not updated with the pick");

endmodule

`default_nettype wire

[tb/counter_priority_task_picker_tb.sv]
// Self-checking testbench for the counter priority task picker.
// It needs ctpt_pkg and the counter_priority_task_picker RTL.
// A scoreboard class models the slot table and checks every pick the block returns.

module counter_priority_task_picker_tb;
   import ctpt_pkg::*;

   localparam int NUM_SLOTS = DEF_NUM_SLOTS;

   // The longest pick is one that reloads. After the last response, this wait
   // is long enough for any stray response to show up.
   localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 10;

   // The receiver holds off for this long once. Meanwhile the sender keeps
   // offering requests, so the two-entry queue fills and the request side stalls.
   localparam int HOLD_OFF_CYCLES = 800;

   localparam int ITEMS_PER_PHASE = 500;

   // This is laid out like bits [9:0] of rsp_tdata, with chosen_slot in the low bits.
   typedef struct packed {
      logic                 starved;
      logic                 reloaded;
      logic                 idle;
      logic                 switch_task;
      logic [SLOT_BITS-1:0] chosen_slot;
   } pick_result;

   // The scoreboard keeps its own copy of the slot table and the running slot.
   // Every accepted pick request adds one expected result to a FIFO, and every
   // response is checked against the oldest entry in that FIFO.
   class pick_scoreboard;
      bit                  present_mark[NUM_SLOTS];
      bit                  runnable_mark[NUM_SLOTS];
      bit [VALUE_BITS-1:0] reload_value[NUM_SLOTS];
      bit [VALUE_BITS-1:0] slice_count[NUM_SLOTS];
      bit [SLOT_BITS-1:0]  running_slot;
      pick_result          expected_picks[$];
      int errors;
      int picks_checked;
      int idle_picks;
      int reload_picks;
      int starved_picks;
      int switch_picks;

      // The scan runs from the top slot down to slot 1. Only a strictly larger
      // count replaces the leader, so the higher slot wins a tie. best_count
      // stays at -1 when no present slot is runnable.
      function bit [SLOT_BITS-1:0] scan_for_leader(output int best_count);
         bit [SLOT_BITS-1:0] leader;
         leader = '0;
         best_count = -1;
         for (int s = NUM_SLOTS - 1; s > 0; s--) begin
            if (present_mark[s] && runnable_mark[s] && int'(slice_count[s]) > best_count) begin
               best_count = int'(slice_count[s]);
               leader = SLOT_BITS'(s);
            end
         end
         return leader;
      endfunction

      function void note_request(logic [KIND_BITS-1:0] kind, logic [REQ_DATA_BITS-1:0] data);
         int         slot;
         int         best_count;
         pick_result pick;
         slot = int'(data[5:0]);
         if (kind == KIND_WRITE_ENTRY || kind == KIND_SET_RUNNABLE) begin
            if (slot < NUM_SLOTS) begin
               runnable_mark[slot] = data[7];
               if (kind == KIND_WRITE_ENTRY) begin
                  present_mark[slot] = data[6];
                  reload_value[slot] = data[15:8];
                  slice_count[slot]  = data[23:16];
               end
            end
         end else if (kind == KIND_SCHEDULE) begin
            pick = '0;
            pick.chosen_slot = scan_for_leader(best_count);
            if (best_count == 0) begin
               // Every present slot is reloaded, whether it is runnable or not.
               // Slot 0 is never reloaded.
               for (int s = 1; s < NUM_SLOTS; s++) begin
                  if (present_mark[s]) begin
                     slice_count[s] = reload_value[s];
                  end
               end
               pick.reloaded = 1'b1;
               pick.chosen_slot = scan_for_leader(best_count);
               pick.starved = (best_count == 0);
            end
            pick.idle = (best_count < 0);
            pick.switch_task = (pick.chosen_slot != running_slot);
            running_slot = pick.chosen_slot;
            expected_picks.push_back(pick);
            idle_picks    += int'(pick.idle);
            reload_picks  += int'(pick.reloaded);
            starved_picks += int'(pick.starved);
            switch_picks  += int'(pick.switch_task);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_pick(logic [RSP_DATA_BITS-1:0] data);
         pick_result want;
         pick_result got;
         got = data[9:0];
         if (expected_picks.size() == 0) begin
            $error("unexpected pick response, chosen_slot %0d", got.chosen_slot);
            errors++;
            return;
         end
         want = expected_picks.pop_front();
         picks_checked++;
         compare_field("chosen_slot", 8'(want.chosen_slot), 8'(got.chosen_slot));
         compare_field("switch_task", 8'(want.switch_task), 8'(got.switch_task));
         compare_field("idle", 8'(want.idle), 8'(got.idle));
         compare_field("reloaded", 8'(want.reloaded), 8'(got.reloaded));
         compare_field("starved", 8'(want.starved), 8'(got.starved));
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [KIND_BITS-1:0]     req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   pick_scoreboard table_model;

   // These set the share of idle cycles on each side for the current phase.
   int send_idle_pct     = 0;
   int rsp_stall_pct     = 0;
   // The main process sets this to ask for a long hold-off. The response process picks it up.
   int rsp_hold_request  = 0;
   // This counts every request except the unused kind.
   int requests_sent     = 0;

   counter_priority_task_picker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Send one request. First it may leave some idle cycles, as the phase allows.
   // Then it holds the request until an edge where req_tready is high. tvalid
   // stays high after the handshake, so back-to-back requests leave no gap.
   task automatic send_request(input logic [KIND_BITS-1:0] kind,
                               input logic [REQ_DATA_BITS-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      table_model.note_request(kind, data);
      if (kind != KIND_UNUSED) begin
         requests_sent++;
      end
   endtask

   task automatic send_entry(input logic [SLOT_BITS-1:0] slot, input logic present,
                             input logic runnable, input logic [VALUE_BITS-1:0] prio,
                             input logic [VALUE_BITS-1:0] count);
      send_request(KIND_WRITE_ENTRY, {count, prio, runnable, present, slot});
   endtask

   // A set-runnable request ignores the present, priority and count bits.
   // They are filled with random values to show that they have no effect.
   task automatic send_runnable(input logic [SLOT_BITS-1:0] slot, input logic runnable);
      logic [REQ_DATA_BITS-1:0] data;
      data = REQ_DATA_BITS'($urandom);
      data[5:0] = slot;
      data[7] = runnable;
      send_request(KIND_SET_RUNNABLE, data);
   endtask

   task automatic send_schedule();
      send_request(KIND_SCHEDULE, REQ_DATA_BITS'($urandom));
   endtask

   // At least one edge passes here, so the next request is never driven in
   // the same time step as the one that dropped tvalid.
   task automatic wait_drained();
      do @(posedge clock); while (table_model.pending() != 0);
   endtask

   // Zero counts are made common on purpose so that reloads happen often.
   // A priority of zero is what makes starvation possible.
   function automatic logic [VALUE_BITS-1:0] random_value(int zero_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < zero_pct) begin
         return '0;
      end else if (roll < zero_pct + 10) begin
         return '1;
      end
      return VALUE_BITS'($urandom_range(255));
   endfunction

   // Random traffic is sent in episodes. Each episode works on a window of
   // eight neighboring slots and clears that window at its end. That keeps the
   // rest of the table empty, so idle picks, reloads and starvation keep
   // coming up. Noise is mixed in: runnable marks set on any slot, and
   // requests of the unused kind.
   task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
      int                   target;
      int                   base;
      int                   len;
      int                   roll;
      logic [SLOT_BITS-1:0] slot;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = requests_sent + items;
      while (requests_sent < target) begin
         base = $urandom_range(NUM_SLOTS - 8);
         len = $urandom_range(40, 10);
         for (int i = 0; i < len; i++) begin
            roll = $urandom_range(99);
            slot = SLOT_BITS'(base + $urandom_range(7));
            if (roll < 30) begin
               send_schedule();
            end else if (roll < 65) begin
               send_entry(slot, $urandom_range(99) < 85, $urandom_range(99) < 60,
                          random_value(20), random_value(45));
            end else if (roll < 88) begin
               send_runnable(slot, 1'($urandom_range(1)));
            end else if (roll < 95) begin
               send_runnable(SLOT_BITS'($urandom_range(NUM_SLOTS - 1)),
                             1'($urandom_range(1)));
            end else begin
               send_request(KIND_UNUSED, REQ_DATA_BITS'($urandom));
            end
         end
         for (int j = 0; j < 8; j++) begin
            send_entry(SLOT_BITS'(base + j), 1'b0, 1'b0, random_value(0), random_value(0));
         end
      end
      // Stop sending until every pick of this phase has been answered.
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   // Response side. A response is checked at each edge where it is accepted.
   // After that, rsp_tready is set for the next cycle: low during a long
   // hold-off, and otherwise random according to the current stall rate.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid === 1'b1 && rsp_tready) begin
               table_model.check_pick(rsp_tdata);
            end
            if (rsp_hold_request > 0) begin
               hold_left = rsp_hold_request;
               rsp_hold_request = 0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
            end
         end
      end
   end

   initial begin
      table_model = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases, sent with no idle cycles on either side.
      // A pick on an empty table gives the idle task, with no reload.
      send_schedule();
      // Slot 0 can be written, but the scan never looks at it.
      send_entry(6'd0, 1'b1, 1'b1, 8'hFF, 8'hFF);
      send_schedule();
      // Slots 63 and 42 have equal counts, so the higher slot wins.
      send_entry(6'd63, 1'b1, 1'b1, 8'hFF, 8'hFF);
      send_entry(6'd42, 1'b1, 1'b1, 8'd7, 8'hFF);
      send_schedule();
      send_schedule();
      send_runnable(6'd63, 1'b0);
      send_schedule();
      // The only runnable count is zero, so counts are reloaded. Slot 63 is
      // present but waiting. It is reloaded too, but the pick cannot choose it.
      send_entry(6'd42, 1'b1, 1'b1, 8'd7, 8'd0);
      send_entry(6'd63, 1'b1, 1'b0, 8'd200, 8'd0);
      send_schedule();
      send_runnable(6'd63, 1'b1);
      send_schedule();
      // Both slots have zero priority, so the reload still leaves zero counts: starvation.
      send_entry(6'd63, 1'b1, 1'b1, 8'd0, 8'd0);
      send_entry(6'd42, 1'b1, 1'b1, 8'd0, 8'd0);
      send_schedule();
      // A slot that is runnable but not present is skipped. The unused kind
      // changes nothing, even with every data bit set.
      send_entry(6'd21, 1'b0, 1'b1, 8'hFF, 8'hFF);
      send_request(KIND_UNUSED, '1);
      send_entry(6'd63, 1'b0, 1'b0, 8'd0, 8'd0);
      send_entry(6'd42, 1'b0, 1'b0, 8'd0, 8'd0);
      send_schedule();
      send_entry(6'd21, 1'b0, 1'b0, 8'd0, 8'd0);
      send_entry(6'd0, 1'b0, 1'b0, 8'd0, 8'd0);
      req_tvalid <= 1'b0;
      wait_drained();

      // Random phases. The first one starts with the long receiver hold-off
      // while the sender runs at full rate.
      rsp_hold_request = HOLD_OFF_CYCLES;
      run_phase(ITEMS_PER_PHASE, 0, 0);
      run_phase(ITEMS_PER_PHASE, 56, 0);
      run_phase(ITEMS_PER_PHASE, 0, 56);
      run_phase(ITEMS_PER_PHASE, 16, 16);

      // Wait a little longer so that any extra response can still arrive and be flagged.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d picks.", requests_sent,
               table_model.picks_checked);
      $display("Of these picks, %0d were idle, %0d reloaded, %0d starved and %0d switched task.",
               table_model.idle_picks, table_model.reload_picks,
               table_model.starved_picks, table_model.switch_picks);
      if (table_model.errors == 0 && table_model.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Limit for the whole run. A correct run needs about 2100 requests. Even if
   // every one were a reloading pick, with idle cycles on both sides and the
   // long hold-off, that stays under this limit.
   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
